// File: hw/rtl/bfm3_pkg.sv
// ----------------------------------------------------------------------------
// bfm3_pkg
// Shared constants, types and small functions for the bloom filter block.
// ----------------------------------------------------------------------------
package bfm3_pkg;

	localparam int          BITS_DEF  = 131072;
	localparam int          KEY_BYTES = 32;
	localparam int          LANES     = 3;
	localparam int          CFG_IDX_W = 2;

	localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
	localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
	localparam logic [63:0] MM_F1 = 64'hff51afd7ed558ccd;
	localparam logic [63:0] MM_F2 = 64'hc4ceb9fe1a85ec53;
	localparam logic [63:0] MM_A1 = 64'h0000000052dce729;
	localparam logic [63:0] MM_A2 = 64'h0000000038495ab5;

	localparam logic [CFG_IDX_W-1:0] REG_SEED_A = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_B = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SEED_C = 2'd2;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef struct packed {
		logic [63:0] w3;
		logic [63:0] w2;
		logic [63:0] w1;
		logic [63:0] w0;
	} key_t;

	function automatic logic [63:0] rotl(input logic [63:0] x, input int r);
		rotl = (x << r) | (x >> (64 - r));
	endfunction

endpackage

// File: hw/rtl/bloom_filter_murmur3_32byte_key.sv
// ----------------------------------------------------------------------------
// bloom_filter_murmur3_32byte_key
// Bloom filter with three parallel MurmurHash3 x64_128 lanes over a bit RAM.
// ----------------------------------------------------------------------------
// channel | dir | handshake               | payload
// s_axis  | in  | s_axis_tvalid/tready    | tdata: key words 0..3, tuser: op
// m_axis  | out | m_axis_tvalid/tready    | tdata[0]: maybe_present
// cfg     | in  | cfg_valid/cfg_ready     | cfg_index, cfg_data (seed a/b/c)
//
// Each word is hashed by three lanes side by side: products on each lane's
// serial 64-bit multiplier, 5 mixing steps, 3 steps for the index fold,
// the index sum and the collection of the lanes. Then the three bits are
// handled in turn on the single RAM port, each by a read, wait and update.
// A query posts its result after its last update; no new word is taken
// while the previous one is still in work.
// After reset a clearing pass sweeps BITS/64 RAM words, one per cycle, with
// s_axis_tready low. A held result stalls only the next query's final step.
// ----------------------------------------------------------------------------
module bloom_filter_murmur3_32byte_key #(
	parameter int BITS = bfm3_pkg::BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [255:0]                   s_axis_tdata,  // key_word_0..key_word_3
	input  logic                           s_axis_tuser,  // op
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	output logic [7:0]                     m_axis_tdata,  // maybe_present, zeros
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfm3_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import bfm3_pkg::*;

	localparam int IW    = $clog2(BITS);
	localparam int WORDS = (BITS + 63) / 64;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;

	localparam logic [2:0] M_CLR  = 3'd0;
	localparam logic [2:0] M_IDLE = 3'd1;
	localparam logic [2:0] M_HASH = 3'd2;
	localparam logic [2:0] M_RD   = 3'd3;
	localparam logic [2:0] M_WAIT = 3'd4;
	localparam logic [2:0] M_UPD  = 3'd5;
	localparam logic [2:0] M_OUT  = 3'd6;

	logic [2:0]    st_q;
	logic [31:0]   seed_q [LANES];
	logic          op_q;
	logic [1:0]    sel_q;
	logic          hit_q;
	logic [AW-1:0] clr_q;
	logic [LANES-1:0] ldone_q;
	logic [LANES-1:0] ldone;
	logic [IW-1:0] idx [LANES];
	logic [IW-1:0] idx_q [LANES];
	logic          go;
	logic [IW-1:0] cur;
	logic [AW-1:0] addr;
	logic          we;
	logic [63:0]   wdata, rdata;
	logic [63:0]   mask;
	key_t          key_in;

	assign key_in = s_axis_tdata;
	assign cfg_ready = 1'b1;
	assign s_axis_tready = (st_q == M_IDLE);
	assign go = s_axis_tvalid && s_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q[0] <= 32'd27;
			seed_q[1] <= 32'd58;
			seed_q[2] <= 32'd99;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_SEED_A: seed_q[0] <= cfg_data;
				REG_SEED_B: seed_q[1] <= cfg_data;
				REG_SEED_C: seed_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		bfm3_lane #(.BITS(BITS)) u_lane (
			.clk(clk), .arst_n(arst_n), .start(go), .key(key_in),
			.seed(seed_q[g]), .done(ldone[g]), .index(idx[g])
		);
	end

	// merge: bits handled in turn, word read-modify-write
	assign cur   = idx_q[sel_q];
	assign mask  = 64'd1 << cur[5:0];
	assign addr  = (st_q == M_CLR) ? clr_q : AW'(cur >> 6);
	assign we    = (st_q == M_CLR) || (st_q == M_UPD && op_q == OP_INSERT);
	assign wdata = (st_q == M_CLR) ? 64'd0 : (rdata | mask);

	bfm3_ram #(.WIDTH(64), .DEPTH(WORDS)) u_ram (
		.clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= M_CLR;
			clr_q <= '0;
			ldone_q <= '0;
			sel_q <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (st_q == M_OUT && (!m_axis_tvalid || m_axis_tready)) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
			unique case (st_q)
				M_CLR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(WORDS - 1)) st_q <= M_IDLE;
				end
				M_IDLE: if (go) begin st_q <= M_HASH; ldone_q <= '0; end
				M_HASH: begin
					ldone_q <= ldone_q | ldone;
					if ((ldone_q | ldone) == '1) begin st_q <= M_RD; sel_q <= '0; end
				end
				M_RD:   st_q <= M_WAIT;
				M_WAIT: st_q <= M_UPD;
				M_UPD: begin
					if (sel_q == 2'(LANES - 1)) st_q <= (op_q == OP_QUERY) ? M_OUT : M_IDLE;
					else begin sel_q <= sel_q + 2'd1; st_q <= M_RD; end
				end
				M_OUT: if (!m_axis_tvalid || m_axis_tready) st_q <= M_IDLE;
				default: st_q <= M_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			op_q  <= s_axis_tuser;
			hit_q <= 1'b1;
		end
		for (int i = 0; i < LANES; i++) if (ldone[i]) idx_q[i] <= idx[i];
		if (st_q == M_UPD && (rdata & mask) == 64'd0) hit_q <= 1'b0;
		if (st_q == M_OUT && (!m_axis_tvalid || m_axis_tready))
			m_axis_tdata <= {7'd0, hit_q};
	end

`ifndef SYNTH
	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q != M_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_out_only_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> op_q == OP_QUERY) else $error("result on insert");
	a_clear_no_write_lane: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == M_CLR) |-> wdata == 64'd0) else $error("clear data");
`endif
endmodule

// File: hw/rtl/bfm3_mul64.sv
// ----------------------------------------------------------------------------
// bfm3_mul64
// Multicycle 64x64 low-half multiplier, one 32x32 partial product per cycle.
// ----------------------------------------------------------------------------
module bfm3_mul64 (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] a,
	input  logic [63:0] b,
	output logic        done,
	output logic [63:0] p
);
	logic [1:0]  step_q;
	logic        busy_q;
	logic [63:0] a_q;
	logic [63:0] b_q;
	logic [63:0] acc_q;
	logic [31:0] op_x;
	logic [31:0] op_y;
	logic [63:0] prod;

	always_comb begin
		case (step_q)
			2'd0:    begin op_x = a_q[31:0];  op_y = b_q[31:0];  end
			2'd1:    begin op_x = a_q[63:32]; op_y = b_q[31:0];  end
			default: begin op_x = a_q[31:0];  op_y = b_q[63:32]; end
		endcase
	end
	assign prod = {32'd0, op_x} * {32'd0, op_y};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= 2'd0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= 2'd0;
			end else if (busy_q) begin
				if (step_q == 2'd2) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
				step_q <= step_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q   <= a;
			b_q   <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (step_q == 2'd0) acc_q <= prod;
			else acc_q <= acc_q + {prod[31:0], 32'd0};
		end
	end
	assign p = acc_q;
endmodule

// File: hw/rtl/bfm3_ram.sv
// ----------------------------------------------------------------------------
// bfm3_ram
// Generic single-port RAM with registered read.
// ----------------------------------------------------------------------------
module bfm3_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 2048
) (
	input  logic                                          clk,
	input  logic                                          we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                              wdata,
	output logic [WIDTH-1:0]                              rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rdata <= mem[addr];
	end
endmodule

// File: hw/rtl/bfm3_lane.sv
// ----------------------------------------------------------------------------
// bfm3_lane
// One MurmurHash3 x64_128 lane: sequencer over its own 64-bit multiplier,
// then index folding by byte residues and a reciprocal multiply.
// ----------------------------------------------------------------------------
module bfm3_lane #(
	parameter int BITS = bfm3_pkg::BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  bfm3_pkg::key_t          key,
	input  logic [31:0]             seed,
	output logic                    done,
	output logic [$clog2(BITS)-1:0] index
);
	import bfm3_pkg::*;

	localparam int IW = $clog2(BITS);
	// folded value is below 2^31; quotient by multiply with ceil(2^MS / BITS)
	localparam int          MS      = 31 + IW;
	localparam logic [63:0] MAGIC64 = ((64'd1 << MS) + 64'(BITS) - 64'd1) / 64'(BITS);
	localparam logic [31:0] MAGIC   = MAGIC64[31:0];
	localparam logic [31:0] BITS32  = 32'(BITS);

	// 2^(8j) mod BITS for each byte position j
	function automatic logic [255:0] byte_res_all();
		logic [255:0] r;
		r = '0;
		for (int j = 0; j < 8; j++) r[32*j +: 32] = 32'((64'd1 << (8*j)) % 64'(BITS));
		return r;
	endfunction

	localparam logic [255:0] BYTE_RES = byte_res_all();

	// congruent to v mod BITS, below 2^31
	function automatic logic [31:0] fold8(input logic [63:0] v);
		logic [31:0] acc;
		acc = '0;
		for (int j = 0; j < 8; j++)
			acc = acc + {24'd0, v[8*j +: 8]} * BYTE_RES[32*j +: 32];
		return acc;
	endfunction

	// step codes
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_P1   = 5'd1;   // p*C1
	localparam logic [4:0] S_P2   = 5'd2;   // rot, *C2
	localparam logic [4:0] S_PA   = 5'd3;   // mix into a
	localparam logic [4:0] S_Q1   = 5'd4;
	localparam logic [4:0] S_Q2   = 5'd5;
	localparam logic [4:0] S_QB   = 5'd6;
	localparam logic [4:0] S_FIN  = 5'd7;
	localparam logic [4:0] S_FA1  = 5'd8;
	localparam logic [4:0] S_FA2  = 5'd9;
	localparam logic [4:0] S_FB1  = 5'd10;
	localparam logic [4:0] S_FB2  = 5'd11;
	localparam logic [4:0] S_MOD  = 5'd12;  // byte fold
	localparam logic [4:0] S_SUM  = 5'd13;
	localparam logic [4:0] S_MQ   = 5'd14;  // quotient
	localparam logic [4:0] S_MR   = 5'd15;  // remainder

	logic [4:0]  st_q;
	logic        wait_q;
	logic        blk_q;
	logic [63:0] a_q, b_q, t_q;
	key_t        key_q;
	logic        m_start;
	logic [63:0] m_a, m_b, m_p;
	logic        m_done;
	logic [31:0] fa_q, fb_q;
	logic [31:0] qta_q, qtb_q;
	logic [IW-1:0] ra_q, rb_q;
	logic [63:0] qa_q, qb_q;
	logic [IW:0] sum;
	logic [63:0] blk_p, blk_q64;

	bfm3_mul64 u_mul (
		.clk(clk), .arst_n(arst_n), .start(m_start),
		.a(m_a), .b(m_b), .done(m_done), .p(m_p)
	);

	assign blk_p   = blk_q ? key_q.w2 : key_q.w0;
	assign blk_q64 = blk_q ? key_q.w3 : key_q.w1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= S_IDLE;
			wait_q <= 1'b0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_IDLE: if (start) begin st_q <= S_P1; wait_q <= 1'b0; end
				S_P1, S_P2, S_Q1, S_Q2, S_FA1, S_FA2, S_FB1, S_FB2: begin
					if (!wait_q) wait_q <= 1'b1;
					else if (m_done) begin
						wait_q <= 1'b0;
						unique case (st_q)
							S_P1:    st_q <= S_P2;
							S_P2:    st_q <= S_PA;
							S_Q1:    st_q <= S_Q2;
							S_Q2:    st_q <= S_QB;
							S_FA1:   st_q <= S_FA2;
							S_FA2:   st_q <= S_FB1;
							S_FB1:   st_q <= S_FB2;
							default: st_q <= S_MOD;
						endcase
					end
				end
				S_PA:  st_q <= S_Q1;
				S_QB:  st_q <= blk_q ? S_FIN : S_P1;
				S_FIN: st_q <= S_FA1;
				S_MOD: st_q <= S_MQ;
				S_MQ:  st_q <= S_MR;
				S_MR:  st_q <= S_SUM;
				S_SUM: begin st_q <= S_IDLE; done <= 1'b1; end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_start = !wait_q && (st_q == S_P1 || st_q == S_P2 || st_q == S_Q1 ||
		st_q == S_Q2 || st_q == S_FA1 || st_q == S_FA2 || st_q == S_FB1 ||
		st_q == S_FB2);

	always_comb begin
		m_a = t_q;
		m_b = MM_C1;
		case (st_q)
			S_P1:  begin m_a = blk_p;   m_b = MM_C1; end
			S_P2:  begin m_a = rotl(t_q, 31); m_b = MM_C2; end
			S_Q1:  begin m_a = blk_q64; m_b = MM_C2; end
			S_Q2:  begin m_a = rotl(t_q, 33); m_b = MM_C1; end
			S_FA1: begin m_a = a_q ^ (a_q >> 33); m_b = MM_F1; end
			S_FA2: begin m_a = t_q ^ (t_q >> 33); m_b = MM_F2; end
			S_FB1: begin m_a = b_q ^ (b_q >> 33); m_b = MM_F1; end
			S_FB2: begin m_a = t_q ^ (t_q >> 33); m_b = MM_F2; end
			default: ;
		endcase
	end

	assign sum = {1'b0, ra_q} + {1'b0, rb_q};

	always_ff @(posedge clk) begin
		logic [63:0] a1, b1, x, pma, pmb;
		a1  = '0;
		b1  = '0;
		x   = '0;
		pma = '0;
		pmb = '0;
		unique case (st_q)
			S_IDLE: if (start) begin
				key_q <= key;
				a_q   <= {32'd0, seed};
				b_q   <= {32'd0, seed};
				blk_q <= 1'b0;
			end
			S_PA: begin
				a1 = rotl(a_q ^ t_q, 27) + b_q;
				a_q <= (a1 << 2) + a1 + MM_A1;
			end
			S_QB: begin
				b1 = rotl(b_q ^ t_q, 31) + a_q;
				b_q <= (b1 << 2) + b1 + MM_A2;
				blk_q <= 1'b1;
			end
			S_FIN: begin
				a1 = a_q ^ 64'(KEY_BYTES);
				b1 = b_q ^ 64'(KEY_BYTES);
				a1 = a1 + b1;
				a_q <= a1;
				b_q <= b1 + a1;
			end
			S_FA2: if (wait_q && m_done) begin
				x = m_p ^ (m_p >> 33);
				a_q <= x;
			end
			S_FB2: if (wait_q && m_done) begin
				x = m_p ^ (m_p >> 33);
				a1 = a_q + x;
				a_q <= a1;
				b_q <= x + a1;
				qa_q <= a1;
				qb_q <= x + a1;
			end
			S_MOD: begin
				fa_q <= fold8(qa_q);
				fb_q <= fold8(qb_q);
			end
			S_MQ: begin
				pma = {32'd0, fa_q} * {32'd0, MAGIC};
				pmb = {32'd0, fb_q} * {32'd0, MAGIC};
				qta_q <= 32'(pma >> MS);
				qtb_q <= 32'(pmb >> MS);
			end
			S_MR: begin
				ra_q <= IW'(fa_q - qta_q * BITS32);
				rb_q <= IW'(fb_q - qtb_q * BITS32);
			end
			S_SUM: begin
				if (sum >= (IW+1)'(BITS)) index <= IW'(sum - (IW+1)'(BITS));
				else index <= IW'(sum);
			end
			default: ;
		endcase
		if (wait_q && m_done && st_q != S_FA2 && st_q != S_FB2) t_q <= m_p;
	end
endmodule

// File: verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bloom filter: keys are streamed in as inserts
// and queries, a local hash and bit-store model predicts every query answer,
// and a monitor compares the answers in order. Seeds change between phases.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import bfm3_pkg::*;

	localparam int NBITS      = BITS_DEF;
	localparam int WDOG_LIMIT = 20000;  // above both the clear pass and one item's processing

	typedef struct {
		logic        op;
		logic [63:0] kw[4];
	} key_word_t;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         s_axis_tvalid = 1'b0;
	logic         s_axis_tready;
	logic [255:0] s_axis_tdata = '0;   // key_word_0..key_word_3
	logic         s_axis_tuser = 1'b0; // op
	logic         m_axis_tvalid;
	logic         m_axis_tready = 1'b0;
	logic [7:0]   m_axis_tdata;        // maybe_present, zeros
	logic         cfg_valid = 1'b0;
	logic         cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0]  cfg_data = '0;

	bloom_filter_murmur3_32byte_key dut (.*);

	always #5 clk = ~clk;

	// model state
	bit          filter_bits[NBITS];
	logic [31:0] seeds[3];

	key_word_t pending_keys[$];
	bit        expected_answers[$];
	int        n_errors = 0;
	int        send_idle_pct = 0;
	int        recv_idle_pct = 0;
	int        idle_cycles = 0;

	function automatic logic [63:0] fmix(logic [63:0] v);
		v ^= v >> 33;
		v *= MM_F1;
		v ^= v >> 33;
		v *= MM_F2;
		v ^= v >> 33;
		return v;
	endfunction

	function automatic logic [63:0] rl(logic [63:0] x, int r);
		return (x << r) | (x >> (64 - r));
	endfunction

	// MurmurHash3 x64_128 over the 32-byte key, folded to a bit position
	function automatic int murmur_pos(key_word_t k, logic [31:0] seed);
		logic [63:0] a, b, p, q;
		a = {32'd0, seed};
		b = a;
		for (int blk = 0; blk < 2; blk++) begin
			p = k.kw[2*blk] * MM_C1;
			p = rl(p, 31) * MM_C2;
			a ^= p;
			a = rl(a, 27) + b;
			a = a * 64'd5 + MM_A1;
			q = k.kw[2*blk+1] * MM_C2;
			q = rl(q, 33) * MM_C1;
			b ^= q;
			b = rl(b, 31) + a;
			b = b * 64'd5 + MM_A2;
		end
		a ^= 64'd32;
		b ^= 64'd32;
		a += b;
		b += a;
		a = fmix(a);
		b = fmix(b);
		a += b;
		b += a;
		return int'(((a % NBITS) + (b % NBITS)) % NBITS);
	endfunction

	// applies one accepted key to the store; queries queue their answer
	task automatic filter_apply(key_word_t k);
		int pos[3];
		bit hit;
		hit = 1'b1;
		foreach (pos[i]) pos[i] = murmur_pos(k, seeds[i]);
		if (k.op == OP_INSERT) begin
			foreach (pos[i]) filter_bits[pos[i]] = 1'b1;
		end else begin
			foreach (pos[i]) hit &= filter_bits[pos[i]];
			expected_answers = {expected_answers, hit};
		end
	endtask

	task automatic report(string what);
		$display("mismatch at %0t: %s", $realtime, what);
		n_errors++;
	endtask

	// driver: presents the head of the queue, pops it on acceptance
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready) begin
				filter_apply(pending_keys.pop_front());
			end
			if ((!s_axis_tvalid || s_axis_tready) && pending_keys.size() > 0
					&& $urandom_range(99) >= send_idle_pct) begin
				s_axis_tvalid <= 1'b1;
				s_axis_tuser  <= pending_keys[0].op;
				s_axis_tdata  <= {pending_keys[0].kw[3], pending_keys[0].kw[2],
				                  pending_keys[0].kw[1], pending_keys[0].kw[0]};
			end else if (s_axis_tvalid && s_axis_tready) begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// monitor: checks answers in order, stalls at random
	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_answers.size() == 0)
					report("answer with none expected");
				else if (m_axis_tdata !== {7'd0, expected_answers[0]}) begin
					report($sformatf("got %h expected %0d", m_axis_tdata,
						expected_answers[0]));
					void'(expected_answers.pop_front());
				end else
					void'(expected_answers.pop_front());
			end
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// watchdog on cycles with no word moving on any channel
	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
				|| (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else if (idle_cycles >= WDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else
			idle_cycles <= idle_cycles + 1;
	end

	task automatic write_seed(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		seeds[idx] = val;
	endtask

	task automatic wait_drained();
		while (pending_keys.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
			@(posedge clk);
		// an insert may still be busy: let one item time pass
		repeat (400) @(posedge clk);
	endtask

	function automatic key_word_t rand_key(logic op);
		key_word_t k;
		k.op = op;
		foreach (k.kw[i]) k.kw[i] = {$urandom, $urandom};
		return k;
	endfunction

	// directed keys: extremes, each op, repeat/inverse membership
	task automatic add_directed();
		key_word_t k;
		key_word_t r;
		k.op = OP_QUERY;
		foreach (k.kw[i]) k.kw[i] = '0;
		pending_keys = {pending_keys, k};       // empty store, all-zero key
		k.op = OP_INSERT;
		pending_keys = {pending_keys, k};
		k.op = OP_QUERY;
		pending_keys = {pending_keys, k};
		foreach (k.kw[i]) k.kw[i] = '1;
		pending_keys = {pending_keys, k};
		k.op = OP_INSERT;
		pending_keys = {pending_keys, k};
		pending_keys = {pending_keys, k};       // inserting twice is harmless
		k.op = OP_QUERY;
		pending_keys = {pending_keys, k};
		for (int i = 0; i < 4; i++) begin
			k.op = OP_INSERT;
			foreach (k.kw[j]) k.kw[j] = (j == i) ? 64'h8000_0000_0000_0001 : 64'd0;
			pending_keys = {pending_keys, k};
			k.op = OP_QUERY;
			pending_keys = {pending_keys, k};
		end
		for (int i = 0; i < 4; i++) begin
			r = rand_key(OP_QUERY);
			pending_keys = {pending_keys, r};
		end
	endtask

	// inserts mixed with queries of recent keys so hits are common
	task automatic add_random(int n);
		key_word_t k;
		key_word_t recent[$];
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(3))
				0: begin
					k = rand_key(OP_INSERT);
					recent = {recent, k};
				end
				1: if (recent.size() > 0) begin
					k = recent[$urandom_range(recent.size() - 1)];
					k.op = OP_QUERY;
				end else k = rand_key(OP_QUERY);
				2: begin
					k = rand_key(OP_QUERY);
					if (recent.size() > 0 && $urandom_range(1)) begin
						k = recent[$urandom_range(recent.size() - 1)];
						k.op = OP_QUERY;
						k.kw[$urandom_range(3)][$urandom_range(63)] ^= 1'b1;
					end
				end
				default: k = rand_key($urandom_range(1));
			endcase
			pending_keys = {pending_keys, k};
		end
	endtask

	initial begin
		seeds[0] = 32'd27;
		seeds[1] = 32'd58;
		seeds[2] = 32'd99;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// default seeds first
		send_idle_pct = 33;
		recv_idle_pct = 83;
		add_directed();
		add_random(200);
		wait_drained();

		// all-ones and zero seeds; store keeps old bits
		write_seed(REG_SEED_A, 32'hffff_ffff);
		write_seed(REG_SEED_B, 32'd0);
		write_seed(REG_SEED_C, 32'hffff_ffff);
		send_idle_pct = 83;
		recv_idle_pct = 33;
		add_random(250);
		wait_drained();

		// random seeds, no idling
		write_seed(REG_SEED_A, $urandom);
		write_seed(REG_SEED_B, $urandom);
		write_seed(REG_SEED_C, $urandom);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(250);
		wait_drained();

		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
